>>> rtl/core/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the capture period to rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;

  // Register indexes (byte address = 4 * index).
  localparam logic [1:0] REG_WHEEL_NUM = 2'd0;
  localparam logic [1:0] REG_FLOW_NUM  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  localparam logic [DATA_W-1:0] TIMEOUT_RST = 32'd1000;
  localparam logic [DATA_W-1:0] RATE_MAX    = 32'hFFFF_FFFF;

  // Operation codes of an input word.
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_CHECK   = 1'b1;

  localparam logic [1:0] FLOW_CHANNEL = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] wheel_numerator;
    logic [DATA_W-1:0] flow_numerator;
    logic [DATA_W-1:0] zero_timeout;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/capture_period_to_rate_unit.sv
// ----------------------------------------------------------------------------
// capture_period_to_rate_unit
// Per-channel capture rate meter: rate = numerator / period (all ones for a zero period), timeout zeroing.
// ----------------------------------------------------------------------------
// Flow: a capture with a nonzero period passes S_EXEC, S_DIV and S_RESULT;
//   the 32 steps of the shared bit-serial divider run in S_DIV. Timeout
//   checks, zero periods and unknown channels go from S_EXEC to S_RESULT.
// Throughput: one word at a time; the next word is taken only back in S_IDLE,
//   after the result word is loaded, which an output stall holds off.
// Reset: synchronous, clears timestamps and rates to zero and the timeout to 1000.
`default_nettype none

module capture_period_to_rate_unit
  import cpr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 3,
  parameter int unsigned TIME_BITS    = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              operation,
  input  wire logic [1:0]        channel,
  input  wire logic [31:0]       time_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [1:0]        channel_out,
  output logic      [31:0]       rate,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [1:0]           state;
  logic                 op_q;
  logic [1:0]           ch_q;
  logic [TIME_BITS-1:0] time_q;

  logic [TIME_BITS-1:0] last_capture [NUM_CHANNELS];
  logic [DATA_W-1:0]    stored_rate  [NUM_CHANNELS];

  logic [4:0]           ch_ext;
  logic                 ch_ok;
  logic [TIME_BITS-1:0] sel_last;
  logic [DATA_W-1:0]    sel_rate;
  logic [TIME_BITS-1:0] dt;
  logic                 need_div;
  logic                 out_free;
  logic                 in_accept;

  cpr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign ch_ext = {3'b000, ch_q};
  assign ch_ok  = (ch_ext < 5'(NUM_CHANNELS));

  always_comb begin
    sel_last = '0;
    sel_rate = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (ch_ext == 5'(i)) begin
        sel_last = last_capture[i];
        sel_rate = stored_rate[i];
      end
    end
  end

  // The period and the timeout gap are the same wrapping difference.
  assign dt       = time_q - sel_last;
  assign need_div = ch_ok && (op_q == OP_CAPTURE) && (dt != '0);

  assign div_req.start    = (state == S_EXEC) && need_div;
  assign div_req.dividend = (ch_q == FLOW_CHANNEL) ? cfg.flow_numerator
                                                   : cfg.wheel_numerator;
  assign div_req.divisor  = DATA_W'(dt);

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q   <= operation;
      ch_q   <= channel;
      time_q <= time_value[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RESULT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_capture[i] <= '0;
        stored_rate[i]  <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (ch_ext == 5'(i)) begin
              if (op_q == OP_CAPTURE) begin
                last_capture[i] <= time_q;
                if (dt == '0) begin
                  stored_rate[i] <= RATE_MAX;
                end
              end else if (DATA_W'(dt) > cfg.zero_timeout) begin
                stored_rate[i] <= '0;
              end
            end
          end
          state <= need_div ? S_DIV : S_RESULT;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (ch_ext == 5'(i)) begin
                stored_rate[i] <= div_rsp.quotient;
              end
            end
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && out_free) begin
      channel_out <= ch_q;
      rate        <= ch_ok ? sel_rate : '0;
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == S_EXEC)
    else $error("accepted word did not start execution");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT) && out_free |=> out_valid && (state == S_IDLE))
    else $error("result word was not loaded");

endmodule

`default_nettype wire

>>> rtl/core/cpr_regs.sv
// ----------------------------------------------------------------------------
// cpr_regs
// APB-style configuration registers: numerators and zero timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_regs
  import cpr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t       regs;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.wheel_numerator <= '0;
      regs.flow_numerator  <= '0;
      regs.zero_timeout    <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WHEEL_NUM: regs.wheel_numerator <= pwdata;
        REG_FLOW_NUM:  regs.flow_numerator  <= pwdata;
        REG_TIMEOUT:   regs.zero_timeout    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WHEEL_NUM: prdata = regs.wheel_numerator;
      REG_FLOW_NUM:  prdata = regs.flow_numerator;
      REG_TIMEOUT:   prdata = regs.zero_timeout;
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/cpr_divider.sv
// ----------------------------------------------------------------------------
// cpr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpr_divider
  import cpr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy)
    else $error("divider did not start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a running division");

endmodule

`default_nettype wire

>>> tb/capture_period_to_rate_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_period_to_rate_unit_tb
// Self-checking bench for the capture period to rate meter. A short table of
// directed words covers reset state, wrapping periods, zero periods, the
// timeout boundary and the unused channel. Random phases follow, each under
// its own register setting. Every result word is checked against an
// in-bench model of per-channel timestamps and rates, or a row's known rate.
// ----------------------------------------------------------------------------

module capture_period_to_rate_unit_tb
  import cpr_pkg::*;
();

  localparam int          NUM_CH      = 3;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          SETTLE_CYC  = 40;
  localparam int          HOLD_AT     = 450;
  localparam int          HOLD_CYC    = 400;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int          DIR_ROWS    = 19;

  typedef struct packed {
    logic [1:0]  ch;
    logic [31:0] rate;
  } rate_word_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  ch;
    logic [31:0] stamp;
    bit          known;
    logic [31:0] rate;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              operation;
  logic [1:0]        channel;
  logic [31:0]       time_value;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        channel_out;
  logic [31:0]       rate;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Model state: one timestamp and one rate per channel, plus the registers.
  logic [31:0] last_stamp [NUM_CH];
  logic [31:0] held_rate [NUM_CH];
  logic [31:0] wheel_num;
  logic [31:0] flow_num;
  logic [31:0] zero_gap;

  rate_word_t pending_rates[$];
  int         mismatches;
  int         words_out;
  int         cycle_count;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_CHECK,   2'd0, 32'd0,          1'b1, 32'd0},
    '{OP_CAPTURE, 2'd3, 32'd123,        1'b1, 32'd0},
    '{OP_CHECK,   2'd3, 32'hFFFF_FFFF,  1'b1, 32'd0},
    '{OP_CAPTURE, 2'd0, 32'd0,          1'b1, RATE_MAX},
    '{OP_CAPTURE, 2'd0, 32'd1000,       1'b0, 32'd0},
    '{OP_CHECK,   2'd0, 32'd2000,       1'b0, 32'd0},
    '{OP_CHECK,   2'd0, 32'd2001,       1'b1, 32'd0},
    '{OP_CAPTURE, 2'd1, 32'hFFFF_FFFF,  1'b0, 32'd0},
    '{OP_CAPTURE, 2'd1, 32'd4,          1'b0, 32'd0},
    '{OP_CAPTURE, 2'd2, 32'd1,          1'b0, 32'd0},
    '{OP_CAPTURE, 2'd2, 32'd1,          1'b1, RATE_MAX},
    '{OP_CAPTURE, 2'd2, 32'd3,          1'b0, 32'd0},
    '{OP_CHECK,   2'd2, 32'd2,          1'b1, 32'd0},
    '{OP_CHECK,   2'd1, 32'd5,          1'b0, 32'd0},
    '{OP_CAPTURE, 2'd1, 32'h8000_0004,  1'b0, 32'd0},
    '{OP_CHECK,   2'd1, 32'h8000_03EC,  1'b0, 32'd0},
    '{OP_CAPTURE, 2'd0, 32'hAAAA_AAAA,  1'b0, 32'd0},
    '{OP_CAPTURE, 2'd0, 32'h5555_5555,  1'b0, 32'd0},
    '{OP_CHECK,   2'd0, 32'h5555_5555,  1'b0, 32'd0}
  };

  capture_period_to_rate_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .channel     (channel),
    .time_value  (time_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .channel_out (channel_out),
    .rate        (rate),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  function automatic rate_word_t predict_rate(logic op, logic [1:0] ch, logic [31:0] stamp);
    rate_word_t  res;
    logic [31:0] span;
    logic [31:0] num;
    res.ch   = ch;
    res.rate = '0;
    if (ch < NUM_CH) begin
      span = stamp - last_stamp[ch];
      if (op == OP_CAPTURE) begin
        num = (ch == FLOW_CHANNEL) ? flow_num : wheel_num;
        last_stamp[ch] = stamp;
        held_rate[ch]  = (span == 0) ? RATE_MAX : num / span;
      end else if (span > zero_gap) begin
        held_rate[ch] = '0;
      end
      res.rate = held_rate[ch];
    end
    return res;
  endfunction

  task automatic note_mismatch(input rate_word_t want, input logic [1:0] got_ch,
                               input logic [31:0] got_rate);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: expected ch %0d rate %h, got ch %0d rate %h",
               $realtime, want.ch, want.rate, got_ch, got_rate);
    end
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WHEEL_NUM: wheel_num = value;
      REG_FLOW_NUM:  flow_num  = value;
      REG_TIMEOUT:   zero_gap  = value;
      default: ;
    endcase
  endtask

  // Offers one word after an idle gap and records its expected result once
  // the block takes it. A known row overrides the model's expectation.
  task automatic send_word(input logic op, input logic [1:0] ch, input logic [31:0] stamp,
                           input int gap, input bit known, input logic [31:0] known_rate);
    rate_word_t want;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    operation  <= op;
    channel    <= ch;
    time_value <= stamp;
    do @(posedge clk); while (in_stall);
    want = predict_rate(op, ch, stamp);
    if (known) want.rate = known_rate;
    pending_rates.push_back(want);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    logic        op;
    logic [1:0]  ch;
    logic [31:0] base;
    logic [31:0] stamp;
    bit          quick;
    int          gap;
    quick = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quick = ($urandom_range(0, 3) == 0);
      gap = quick ? 0 : $urandom_range(0, 17);
      ch  = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      op  = ($urandom_range(0, 4) < 3) ? OP_CAPTURE : OP_CHECK;
      base = (ch < NUM_CH) ? last_stamp[ch] : 32'd0;
      // Mostly stamps near the previous capture, so rates stay meaningful.
      case ($urandom_range(0, 9))
        0, 1:    stamp = $urandom();
        2:       stamp = base;
        3, 4:    stamp = base + zero_gap + 32'($urandom_range(0, 2)) - 32'd1;
        default: stamp = base + ($urandom() >> $urandom_range(4, 31));
      endcase
      send_word(op, ch, stamp, gap, 1'b0, '0);
    end
  endtask

  // Result side: random stall ahead of each word, quick stretches, and one
  // long hold that backs the block up into its input.
  initial begin
    bit quick;
    int wait_cyc;
    quick = 1'b0;
    @(negedge rst);
    forever begin
      if (words_out == HOLD_AT) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
      end
      if (words_out % 64 == 0) quick = ($urandom_range(0, 3) == 0);
      wait_cyc = quick ? 0 : $urandom_range(0, 17);
      repeat (wait_cyc) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    rate_word_t want;
    if (!rst && out_valid && !out_stall) begin
      words_out++;
      if (pending_rates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word at %0t: ch %0d rate %h", $realtime, channel_out, rate);
        end
      end else begin
        want = pending_rates.pop_front();
        if (channel_out !== want.ch || rate !== want.rate) begin
          note_mismatch(want, channel_out, rate);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = OP_CAPTURE;
    channel    = '0;
    time_value = '0;
    out_stall  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    mismatches = 0;
    words_out  = 0;
    cycle_count = 0;
    wheel_num  = '0;
    flow_num   = '0;
    zero_gap   = TIMEOUT_RST;
    for (int c = 0; c < NUM_CH; c++) begin
      last_stamp[c] = '0;
      held_rate[c]  = '0;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The timeout keeps its reset value for the directed rows; a write to
    // the unused index must not disturb it.
    reg_write(REG_WHEEL_NUM, 32'd1_000_000);
    reg_write(REG_FLOW_NUM, 32'hFFFF_FFFF);
    reg_write(REG_UNUSED, 32'd0);
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_word(dir_rows[r].op, dir_rows[r].ch, dir_rows[r].stamp, $urandom_range(0, 17),
                dir_rows[r].known, dir_rows[r].rate);
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        1: begin
          reg_write(REG_WHEEL_NUM, 32'd0);
          reg_write(REG_FLOW_NUM, 32'd0);
          reg_write(REG_TIMEOUT, 32'd0);
        end
        2: begin
          reg_write(REG_WHEEL_NUM, 32'hFFFF_FFFF);
          reg_write(REG_FLOW_NUM, 32'hFFFF_FFFF);
          reg_write(REG_TIMEOUT, 32'hFFFF_FFFF);
        end
        default: begin
          reg_write(REG_WHEEL_NUM, $urandom() >> $urandom_range(0, 20));
          reg_write(REG_FLOW_NUM, $urandom() >> $urandom_range(0, 20));
          reg_write(REG_TIMEOUT, $urandom() >> $urandom_range(8, 31));
          reg_write(REG_UNUSED, $urandom());
        end
      endcase
      run_random((ph == 1 || ph == 2) ? 150 : 200);
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
